FILE: hdl/fvn_pkg.sv
package fvn_pkg;

  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned TBL_AW     = $clog2(TABLE_SIZE);
  localparam int unsigned MAX_OCT    = 8;
  localparam int unsigned OCT_W      = $clog2(MAX_OCT);
  localparam int unsigned OCT_CFG_W  = 4;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned NOISE_W    = 16;
  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned PX_W       = FRAC_BITS + TBL_AW;
  localparam int unsigned DVD_W      = 24;
  localparam int unsigned DVS_W      = 8;

  localparam logic [FREQ_W-1:0]    FREQ_RST = FREQ_W'(65536);
  localparam logic [OCT_CFG_W-1:0] OCT_RST  = OCT_CFG_W'(1);

  typedef enum logic {
    REG_FREQ = 1'b0,
    REG_OCT  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_EVAL = 1'b1
  } mode_e;

endpackage

FILE: hdl/fvn_in_if.sv
interface fvn_in_if;
  import fvn_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [TBL_AW-1:0]             table_index;
  logic [TBL_AW-1:0]             table_value;
  logic [COORD_W-1:0]            x_coord;
  logic [COORD_W-1:0]            y_coord;
  modport source (output valid, mode, table_index, table_value, x_coord, y_coord,
                  input ready);
  modport sink   (input valid, mode, table_index, table_value, x_coord, y_coord,
                  output ready);
endinterface

FILE: hdl/fvn_out_if.sv
interface fvn_out_if;
  import fvn_pkg::*;
  logic               valid;
  logic               ready;
  logic [NOISE_W-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

FILE: hdl/fractal_value_noise_2d.sv
// Fractal value noise over a 2-D point. A load transfer (mode 0) writes one
// entry of the 256-entry permutation table; entries must be written before an
// evaluation reads them. An evaluate transfer (mode 1) runs through one shared
// 25x25 multiplier and a table with a single read port: the setup states ST_MX,
// ST_MY and ST_PY, the octave states ST_A0 to ST_A8 once per octave, then a
// bit-serial divide and the output state ST_OUT. The input is not ready while an
// item is in progress; a finished result waits in the output register while the
// next item is taken. Configure frequency (0x0) and octave_count (0x4) only
// while idle.
module fractal_value_noise_2d (
  input  logic        clk_i,
  input  logic        rst_ni,
  fvn_in_if.sink      in_i,
  fvn_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fvn_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MX, ST_MY, ST_PY,
    ST_A0, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5, ST_A6, ST_A7, ST_A8,
    ST_DS, ST_DW, ST_OUT
  } state_e;

  state_e                  state_q;
  logic [FREQ_W-1:0]       freq_q;
  logic [OCT_CFG_W-1:0]    oct_cfg_q;
  logic [OCT_CFG_W-1:0]    oct_q;
  logic [OCT_W-1:0]        oi_q;
  logic                    out_valid_q;
  logic [NOISE_W-1:0]      noise_q;

  logic [COORD_W-1:0]      x_q, y_q;
  logic [PX_W-1:0]         px_q, py_q;
  logic [TBL_AW-1:0]       row0_q, row1_q, c00_q, c10_q, c01_q;
  logic [16:0]             wx_q, wy_q;
  logic [23:0]             lo_q;
  logic [31:0]             sum_q;
  logic [DVD_W-1:0]        quot_q;

  logic [TBL_AW-1:0]       mem_q [TABLE_SIZE];
  logic [TBL_AW-1:0]       rd_q;
  logic [TBL_AW-1:0]       rd_addr;

  logic signed [24:0]      mul_a, mul_b;
  logic signed [49:0]      prod_q;

  logic                    in_xfer, cfg_wr, last_oct;
  logic [TBL_AW-1:0]       xi, yi;
  logic [15:0]             sx, sy;
  logic [17:0]             polyx, polyy;
  logic [8:0]              d0, d1;
  logic [25:0]             lo_full, hi_full, n_full;
  logic [24:0]             diff;
  logic [OCT_CFG_W-1:0]    oct_sat;
  logic                    div_start, div_done;
  logic [DVD_W-1:0]        div_quot, dividend;
  logic [DVS_W-1:0]        divisor;
  logic [4:0]              dsh;

  assign in_i.ready        = (state_q == ST_IDLE);
  assign in_xfer           = in_i.valid && in_i.ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.noise_value = noise_q;
  assign pready            = 1'b1;
  assign cfg_wr            = psel && penable && pwrite;
  assign prdata            = (reg_idx_e'(paddr[2]) == REG_OCT) ?
                             {{(32-OCT_CFG_W){1'b0}}, oct_cfg_q} :
                             {{(32-FREQ_W){1'b0}}, freq_q};

  assign oct_sat  = (oct_cfg_q == '0) ? OCT_CFG_W'(1) :
                    (oct_cfg_q > OCT_CFG_W'(MAX_OCT)) ? OCT_CFG_W'(MAX_OCT) : oct_cfg_q;
  assign last_oct = (OCT_CFG_W'(oi_q) + OCT_CFG_W'(1)) == oct_q;

  assign xi    = px_q[PX_W-1:FRAC_BITS];
  assign yi    = py_q[PX_W-1:FRAC_BITS];
  assign sx    = px_q[FRAC_BITS-1:FRAC_BITS-16];
  assign sy    = py_q[FRAC_BITS-1:FRAC_BITS-16];
  assign polyx = 18'(3 * 65536) - {1'b0, sx, 1'b0};
  assign polyy = 18'(3 * 65536) - {1'b0, sy, 1'b0};
  assign d0    = {1'b0, c10_q} - {1'b0, c00_q};
  assign d1    = {1'b0, rd_q} - {1'b0, c01_q};
  assign lo_full = {2'b0, c00_q, 16'b0} + prod_q[25:0];
  assign hi_full = {2'b0, c01_q, 16'b0} + prod_q[25:0];
  assign diff    = {1'b0, hi_full[23:0]} - {1'b0, lo_q};
  assign n_full  = {2'b0, lo_q} + prod_q[41:16];

  assign dsh      = 5'd16 - {1'b0, oct_q};
  assign dividend = DVD_W'(sum_q >> dsh);
  assign divisor  = DVS_W'((9'd1 << oct_q) - 9'd1);
  assign div_start = (state_q == ST_DS);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    rd_addr = yi;
    case (state_q)
      ST_MX: begin mul_a = {1'b0, x_q}; mul_b = {1'b0, freq_q}; end
      ST_MY: begin mul_a = {1'b0, y_q}; mul_b = {1'b0, freq_q}; end
      ST_A0: begin mul_a = {9'b0, sx}; mul_b = {9'b0, sx}; rd_addr = yi; end
      ST_A1: begin
        mul_a = {9'b0, prod_q[31:16]}; mul_b = {7'b0, polyx};
        rd_addr = yi + TBL_AW'(1);
      end
      ST_A2: begin mul_a = {9'b0, sy}; mul_b = {9'b0, sy}; rd_addr = row0_q + xi; end
      ST_A3: begin
        mul_a = {9'b0, prod_q[31:16]}; mul_b = {7'b0, polyy};
        rd_addr = row0_q + xi + TBL_AW'(1);
      end
      ST_A4: rd_addr = row1_q + xi;
      ST_A5: begin
        mul_a = {{16{d0[8]}}, d0}; mul_b = {8'b0, wx_q};
        rd_addr = row1_q + xi + TBL_AW'(1);
      end
      ST_A6: begin mul_a = {{16{d1[8]}}, d1}; mul_b = {8'b0, wx_q}; end
      ST_A7: begin mul_a = diff; mul_b = {8'b0, wy_q}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && mode_e'(in_i.mode) == MODE_LOAD) mem_q[in_i.table_index] <= in_i.table_value;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_xfer) begin
      x_q <= in_i.x_coord;
      y_q <= in_i.y_coord;
    end
    case (state_q)
      ST_MY: px_q <= prod_q[PX_W-1:0];
      ST_PY: begin py_q <= prod_q[PX_W-1:0]; sum_q <= '0; end
      ST_A1: row0_q <= rd_q;
      ST_A2: begin row1_q <= rd_q; wx_q <= prod_q[32:16]; end
      ST_A3: c00_q <= rd_q;
      ST_A4: begin c10_q <= rd_q; wy_q <= prod_q[32:16]; end
      ST_A5: c01_q <= rd_q;
      ST_A6: lo_q <= lo_full[23:0];
      ST_A8: begin
        sum_q <= sum_q + (32'(n_full[23:0]) << (OCT_W'(MAX_OCT - 1) - oi_q));
        px_q  <= {px_q[PX_W-2:0], 1'b0};
        py_q  <= {py_q[PX_W-2:0], 1'b0};
      end
      ST_DW: if (div_done) quot_q <= div_quot;
      ST_OUT: if (!out_valid_q) noise_q <= (|quot_q[DVD_W-1:NOISE_W]) ? '1 : quot_q[NOISE_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      freq_q      <= FREQ_RST;
      oct_cfg_q   <= OCT_RST;
      oct_q       <= OCT_RST;
      oi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (reg_idx_e'(paddr[2]) == REG_OCT) oct_cfg_q <= pwdata[OCT_CFG_W-1:0];
        else freq_q <= pwdata[FREQ_W-1:0];
      end
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (in_xfer && mode_e'(in_i.mode) == MODE_EVAL) begin
          oct_q   <= oct_sat;
          oi_q    <= '0;
          state_q <= ST_MX;
        end
        ST_MX: state_q <= ST_MY;
        ST_MY: state_q <= ST_PY;
        ST_PY: state_q <= ST_A0;
        ST_A0: state_q <= ST_A1;
        ST_A1: state_q <= ST_A2;
        ST_A2: state_q <= ST_A3;
        ST_A3: state_q <= ST_A4;
        ST_A4: state_q <= ST_A5;
        ST_A5: state_q <= ST_A6;
        ST_A6: state_q <= ST_A7;
        ST_A7: state_q <= ST_A8;
        ST_A8: begin
          oi_q    <= oi_q + OCT_W'(1);
          state_q <= last_oct ? ST_DS : ST_A0;
        end
        ST_DS: state_q <= ST_DW;
        ST_DW: if (div_done) state_q <= ST_OUT;
        ST_OUT: if (!out_valid_q) begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  fvn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

endmodule

FILE: hdl/fvn_div.sv
module fvn_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fvn_pkg::DVD_W-1:0]   dividend_i,
  input  logic [fvn_pkg::DVS_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [fvn_pkg::DVD_W-1:0]   quot_o
);
  import fvn_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic                busy_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DVD_W-1:0]    dvd_q;
  logic [DVS_W-1:0]    dvs_q;
  logic [DVS_W-1:0]    rem_q;
  logic [DVS_W:0]      trial;
  logic                fits;

  assign trial  = {rem_q, dvd_q[DVD_W-1]};
  assign fits   = trial >= {1'b0, dvs_q};
  assign done_o = busy_q && (cnt_q == CNT_W'(DVD_W - 1));
  assign quot_o = {dvd_q[DVD_W-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (done_o) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    end
  end

endmodule

FILE: hdl/fvn_chk.sv
module fvn_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_mode_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [fvn_pkg::NOISE_W-1:0] noise_i
);
  import fvn_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(noise_i))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_mode_i |=> !in_ready_i)
    else $error("input ready right after an evaluate transfer");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_mode_i |=> !$rose(out_valid_i))
    else $error("load produced a result");

endmodule

bind fractal_value_noise_2d fvn_chk u_fvn_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .noise_i     (out_o.noise_value)
);

FILE: tb/testbench.sv
module testbench;
  import fvn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 120;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned RAND_ITEMS  = 630;

  typedef struct {
    mode_e             mode;
    logic [TBL_AW-1:0] idx;
    logic [TBL_AW-1:0] val;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    bit                typed;
    logic [NOISE_W-1:0] noise;
  } stim_row_t;

  typedef struct {
    logic [NOISE_W-1:0] noise;
  } noise_exp_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  fvn_in_if  in_if();
  fvn_out_if out_if();

  fractal_value_noise_2d DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [TBL_AW-1:0]  perm_mdl [TABLE_SIZE];
  logic [FREQ_W-1:0]  freq_mdl;
  logic [OCT_CFG_W-1:0] oct_mdl;
  noise_exp_t noise_q[$];
  bit   typed_now;
  logic [NOISE_W-1:0] typed_val;
  int   errors;
  int   cycles;
  bit   calm;
  bit   hold_req;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] smooth(logic [63:0] s);
    logic [63:0] sq;
    sq = (s * s) >> 16;
    return (sq * (64'd196608 - 2 * s)) >> 16;
  endfunction

  function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] w);
    return (a * (64'd65536 - w) + b * w) >> 16;
  endfunction

  function automatic logic [63:0] lattice(logic [TBL_AW-1:0] xi, logic [TBL_AW-1:0] yi);
    logic [TBL_AW-1:0] row;
    row = perm_mdl[yi];
    return 64'(perm_mdl[TBL_AW'(row + xi)]) << 16;
  endfunction

  function automatic logic [63:0] octave_val(logic [63:0] px, logic [63:0] py);
    logic [TBL_AW-1:0] xi, yi, xn, yn;
    logic [63:0] wx, wy, lo, hi;
    xi = px[FRAC_BITS +: TBL_AW];
    yi = py[FRAC_BITS +: TBL_AW];
    xn = xi + 1'b1;
    yn = yi + 1'b1;
    wx = smooth(64'(px[FRAC_BITS-1 -: 16]));
    wy = smooth(64'(py[FRAC_BITS-1 -: 16]));
    lo = mix(lattice(xi, yi), lattice(xn, yi), wx);
    hi = mix(lattice(xi, yn), lattice(xn, yn), wx);
    return mix(lo, hi, wy);
  endfunction

  function automatic logic [NOISE_W-1:0] fractal_noise(logic [COORD_W-1:0] x,
                                                       logic [COORD_W-1:0] y);
    logic [63:0] px, py, acc, dv, q;
    int unsigned n;
    n = oct_mdl;
    if (n < 1) n = 1;
    if (n > MAX_OCT) n = MAX_OCT;
    px = 64'(x) * 64'(freq_mdl);
    py = 64'(y) * 64'(freq_mdl);
    acc = 0;
    dv = 0;
    for (int i = 0; i < n; i++) begin
      acc += octave_val(px << i, py << i) << (MAX_OCT - 1 - i);
      dv += 64'(TABLE_SIZE) << (MAX_OCT - 1 - i);
    end
    q = acc / dv;
    if (q > 64'hFFFF) q = 64'hFFFF;
    return q[NOISE_W-1:0];
  endfunction

  task automatic report(string what, logic [NOISE_W-1:0] got, logic [NOISE_W-1:0] want);
    $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // accepted inputs feed the predictor; accepted outputs are checked
  always @(posedge clk_i) begin
    noise_exp_t e;
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (in_if.mode == MODE_LOAD) begin
        perm_mdl[in_if.table_index] = in_if.table_value;
      end else begin
        e.noise = fractal_noise(in_if.x_coord, in_if.y_coord);
        if (typed_now && e.noise != typed_val) report("predictor vs table", e.noise, typed_val);
        noise_q.push_back(e);
      end
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (noise_q.size() == 0) begin
        report("unexpected noise transfer", out_if.noise_value, '0);
      end else begin
        e = noise_q.pop_front();
        if (out_if.noise_value != e.noise) report("noise_value", out_if.noise_value, e.noise);
      end
    end
  end

  initial begin
    out_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send(mode_e m, logic [TBL_AW-1:0] idx, logic [TBL_AW-1:0] val,
                      logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= m;
    in_if.table_index <= idx;
    in_if.table_value <= val;
    in_if.x_coord     <= x;
    in_if.y_coord     <= y;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic apb_write(reg_idx_e r, logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_FREQ) freq_mdl = d[FREQ_W-1:0];
    else oct_mdl = d[OCT_CFG_W-1:0];
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return COORD_W'($urandom);
      1: return COORD_W'($urandom_range(0, 16'hFFFF));
      2: return COORD_W'({$urandom_range(0, 7), 12'($urandom)});
      default: return {COORD_W{1'b1}} - COORD_W'($urandom_range(0, 255));
    endcase
  endfunction

  stim_row_t directed[] = '{
    '{MODE_EVAL, 8'h00, 8'h00, 24'h000000, 24'h000000, 1'b1, 16'hFF00},
    '{MODE_EVAL, 8'h00, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 16'hFF00},
    '{MODE_EVAL, 8'h00, 8'h00, 24'h000800, 24'hFFF7FF, 1'b1, 16'hFF00},
    '{MODE_LOAD, 8'h00, 8'h00, 24'h000000, 24'h000000, 1'b0, 16'h0000},
    '{MODE_LOAD, 8'hFF, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 16'h0000},
    '{MODE_LOAD, 8'h01, 8'h80, 24'h000000, 24'h000000, 1'b0, 16'h0000},
    '{MODE_LOAD, 8'h80, 8'h01, 24'h000000, 24'h000000, 1'b0, 16'h0000},
    '{MODE_LOAD, 8'h7F, 8'hFE, 24'h000000, 24'h000000, 1'b0, 16'h0000},
    '{MODE_EVAL, 8'h00, 8'h00, 24'h000000, 24'h000000, 1'b0, 16'h0000},
    '{MODE_EVAL, 8'h00, 8'h00, 24'h001000, 24'h000000, 1'b0, 16'h0000},
    '{MODE_EVAL, 8'h00, 8'h00, 24'h000800, 24'h000800, 1'b0, 16'h0000},
    '{MODE_EVAL, 8'h00, 8'h00, 24'h000FFF, 24'h000FFF, 1'b0, 16'h0000},
    '{MODE_EVAL, 8'h00, 8'h00, 24'hFFFFFF, 24'h000000, 1'b0, 16'h0000},
    '{MODE_EVAL, 8'h00, 8'h00, 24'h000000, 24'hFFFFFF, 1'b0, 16'h0000},
    '{MODE_EVAL, 8'h00, 8'h00, 24'h0FF800, 24'h7FF000, 1'b0, 16'h0000}
  };

  logic [FREQ_W-1:0]    freq_set [] = '{24'h000000, 24'hFFFFFF, 24'h010000, 24'h008000,
                                         24'h000001, 24'h03A000, 24'h010000};
  logic [OCT_CFG_W-1:0] oct_set  [] = '{4'd0, 4'd15, 4'd8, 4'd3, 4'd9, 4'd5, 4'd1};

  initial begin
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    typed_now = 1'b0;
    typed_val = '0;
    freq_mdl = FREQ_RST;
    oct_mdl = OCT_RST;
    foreach (perm_mdl[i]) perm_mdl[i] = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.mode = MODE_LOAD; in_if.table_index = '0;
    in_if.table_value = '0; in_if.x_coord = '0; in_if.y_coord = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < TABLE_SIZE; i++) send(MODE_LOAD, TBL_AW'(i), 8'hFF, '0, '0);
    foreach (directed[i]) begin
      typed_now <= directed[i].typed;
      typed_val <= directed[i].noise;
      send(directed[i].mode, directed[i].idx, directed[i].val, directed[i].x, directed[i].y);
    end
    typed_now <= 1'b0;
    drain();

    foreach (freq_set[p]) begin
      apb_write(REG_FREQ, 32'(freq_set[p]));
      apb_write(REG_OCT, 32'(oct_set[p]));
      if (p == 2) hold_req = 1'b1;
      if (p == freq_set.size() - 1) calm = 1'b1;
      for (int k = 0; k < RAND_ITEMS / freq_set.size(); k++) begin
        if ($urandom_range(0, 3) == 0)
          send(MODE_LOAD, TBL_AW'($urandom), TBL_AW'($urandom), rand_coord(), rand_coord());
        else
          send(MODE_EVAL, TBL_AW'($urandom), TBL_AW'($urandom), rand_coord(), rand_coord());
      end
      drain();
    end

    if (noise_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/fvn_pkg.sv
hdl/fvn_in_if.sv
hdl/fvn_out_if.sv
hdl/fvn_div.sv
hdl/fractal_value_noise_2d.sv
hdl/fvn_chk.sv
tb/testbench.sv
